// ===== sv/dual_threshold_vad_segmenter_core_defines.svh =====
// Assertion macros for the dual-threshold VAD segmenter.
// Included by the modules that carry concurrent assertions.
`ifndef DUAL_THRESHOLD_VAD_SEGMENTER_CORE_DEFINES_SVH
`define DUAL_THRESHOLD_VAD_SEGMENTER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define DTVAD_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("dtvad assertion failed");
`define DTVAD_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("dtvad assertion failed");
`else
`define DTVAD_ASSERT(lbl, clk, rstn, prop)
`define DTVAD_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

// ===== sv/dtvad_pkg.sv =====
// Package of the dual-threshold VAD segmenter: payload types, config
// registers, sequencer state codes. No dependencies.
`timescale 1ns / 1ps
package dtvad_pkg;

  localparam int unsigned MaxFramesDef   = 4096;
  localparam int unsigned MaxSegmentsDef = 64;
  localparam int unsigned CfgIdxW        = 3;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ENERGY_HIGH   = 3'd0,
    REG_ENERGY_LOW    = 3'd1,
    REG_ZCR_THRESHOLD = 3'd2,
    REG_GAP_FRAMES    = 3'd3,
    REG_FRAME_SHIFT   = 3'd4,
    REG_TOTAL_SAMPLES = 3'd5
  } reg_idx_e;

  typedef struct packed {
    logic [31:0] frame_energy;
    logic [15:0] frame_zcr;
    logic        last_frame;
  } frame_t;

  typedef struct packed {
    logic [31:0] seg_start;
    logic [31:0] seg_end;
    logic        seg_valid;
    logic        last_result;
    logic        overflow;
  } seg_t;

  typedef struct packed {
    logic [31:0] energy_high;
    logic [31:0] energy_low;
    logic [15:0] zcr_threshold;
    logic [11:0] gap_frames;
    logic [15:0] frame_shift;
    logic [31:0] total_samples;
  } cfg_t;

  typedef struct packed {
    logic valid;
    seg_t seg;
  } seg_req_t;

  typedef enum logic [3:0] {
    ST_LOAD, ST_START, ST_RD0, ST_RD1, ST_RD2, ST_EVAL, ST_WRD, ST_WCK,
    ST_FILL, ST_MUL, ST_EMIT, ST_EMPTY, ST_NEXT, ST_PEND, ST_FIN
  } st_e;

  typedef enum logic [1:0] {
    PH_GROW, PH_GAP, PH_COUNT, PH_EMIT
  } phase_e;

endpackage

// ===== sv/dtvad_mem.sv =====
// Single-port-write, single-port-read synchronous memory with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dtvad_mem #(
  parameter int unsigned Depth = 4096,
  parameter int unsigned Width = 1
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sv/dtvad_seq.sv =====
// Frame loader and decision sequencer: stores flags, grows and merges
// speech marks, emits segments. Uses dtvad_pkg and dtvad_mem.
`timescale 1ns / 1ps
`include "dual_threshold_vad_segmenter_core_defines.svh"
module dtvad_seq #(
  parameter int unsigned MAX_FRAMES   = dtvad_pkg::MaxFramesDef,
  parameter int unsigned MAX_SEGMENTS = dtvad_pkg::MaxSegmentsDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  dtvad_pkg::cfg_t   cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  dtvad_pkg::frame_t in_data_i,
  output dtvad_pkg::seg_req_t seg_req_o,
  input  logic              seg_taken_i
);
  import dtvad_pkg::*;

  localparam int unsigned AW  = $clog2(MAX_FRAMES);
  localparam int unsigned IW  = $clog2(MAX_FRAMES + 2);
  localparam int unsigned SW  = $clog2(MAX_SEGMENTS + 1);
  localparam int unsigned PW  = (IW + 16 > 32) ? IW + 16 : 32;
  localparam int unsigned DW  = (IW > 12) ? IW : 12;

  st_e    st_q, st_d;
  phase_e ph_q, ph_d;
  logic [1:0]    pass_q, pass_d;
  logic [IW-1:0] cnt_q, cnt_d;
  logic [IW-1:0] n_q, n_d;
  logic [IW-1:0] i_q, i_d;
  logic [IW-1:0] p_q, p_d;
  logic [IW-1:0] gp_q, gp_d;
  logic          drop_q, drop_d;
  logic          segovf_q, segovf_d;
  logic [SW-1:0] seg_cnt_q, seg_cnt_d;
  logic [SW-1:0] emit_cnt_q, emit_cnt_d;
  logic          dir_q, dir_d;
  logic          up_q, up_d;
  logic          a_q, a_d;
  logic          b_q, b_d;
  logic [1:0]    bf_q, bf_d;
  logic [31:0]   start_q, start_d;
  logic [31:0]   end_q, end_d;

  logic          mark_we, flag_we, mem_re;
  logic [AW-1:0] waddr, raddr;
  logic          mark_wdata;
  logic [1:0]    flag_wdata;
  logic          mark_rdata;
  logic [1:0]    flag_rdata;

  logic          in_acc;
  logic          room;
  logic [IW-1:0] i_m1, i_m2, p_m1, pn_gap, pn_seg;
  logic          fb, c_mark, cond1, cond2, f_walk, i_last, walk_range;
  logic [DW-1:0] gap_dist;
  logic [PW-1:0] start_prod, end_prod;

  dtvad_mem #(.Depth(MAX_FRAMES), .Width(1)) u_mark_mem (
    .clk_i  (clk_i),
    .we_i   (mark_we),
    .waddr_i(waddr),
    .wdata_i(mark_wdata),
    .re_i   (mem_re),
    .raddr_i(raddr),
    .rdata_o(mark_rdata)
  );

  dtvad_mem #(.Depth(MAX_FRAMES), .Width(2)) u_flag_mem (
    .clk_i  (clk_i),
    .we_i   (flag_we),
    .waddr_i(waddr),
    .wdata_i(flag_wdata),
    .re_i   (mem_re),
    .raddr_i(raddr),
    .rdata_o(flag_rdata)
  );

  assign in_acc     = in_valid_i && (st_q == ST_LOAD);
  assign room       = cnt_q < IW'(MAX_FRAMES);
  assign i_m1       = i_q - IW'(1);
  assign i_m2       = i_q - IW'(2);
  assign p_m1       = p_q - IW'(1);
  assign c_mark     = mark_rdata;
  assign fb         = pass_q[0] ? bf_q[0] : bf_q[1];
  assign f_walk     = pass_q[0] ? flag_rdata[0] : flag_rdata[1];
  assign cond1      = !b_q && c_mark;
  assign cond2      = a_q && !b_q && !(cond1 && fb);
  assign i_last     = (i_q + IW'(1)) == n_q;
  assign walk_range = (p_q != '0) && (p_q <= n_q);
  assign pn_gap     = (a_q && !b_q) ? i_q : gp_q;
  assign pn_seg     = (!a_q && b_q) ? i_q : gp_q;
  assign gap_dist   = DW'(i_q - pn_gap);
  assign start_prod = PW'(p_m1) * PW'(cfg_i.frame_shift);
  assign end_prod   = PW'(i_q) * PW'(cfg_i.frame_shift);

  // next state and datapath
  always_comb begin
    st_d       = st_q;
    ph_d       = ph_q;
    pass_d     = pass_q;
    cnt_d      = cnt_q;
    n_d        = n_q;
    i_d        = i_q;
    p_d        = p_q;
    gp_d       = gp_q;
    drop_d     = drop_q;
    segovf_d   = segovf_q;
    seg_cnt_d  = seg_cnt_q;
    emit_cnt_d = emit_cnt_q;
    dir_d      = dir_q;
    up_d       = up_q;
    a_d        = a_q;
    b_d        = b_q;
    bf_d       = bf_q;
    start_d    = start_q;
    end_d      = end_q;
    unique case (st_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (room) begin
            cnt_d = cnt_q + IW'(1);
          end else begin
            drop_d = 1'b1;
          end
          if (in_data_i.last_frame) begin
            n_d  = room ? cnt_q + IW'(1) : cnt_q;
            st_d = ST_START;
          end
        end
      end
      ST_START: begin
        i_d  = IW'(2);
        gp_d = IW'(1);
        st_d = (n_q >= IW'(3)) ? ST_RD0 : ST_PEND;
      end
      ST_RD0: st_d = ST_RD1;
      ST_RD1: begin
        a_d  = mark_rdata;
        st_d = ST_RD2;
      end
      ST_RD2: begin
        b_d  = mark_rdata;
        bf_d = flag_rdata;
        st_d = ST_EVAL;
      end
      ST_EVAL: begin
        st_d = ST_NEXT;
        unique case (ph_q)
          PH_GROW: begin
            up_d = cond2;
            p_d  = i_q;
            if (cond1) begin
              dir_d = 1'b0;
              st_d  = ST_WRD;
            end else if (cond2) begin
              dir_d = 1'b1;
              up_d  = 1'b0;
              st_d  = ST_WRD;
            end
          end
          PH_GAP: begin
            gp_d = pn_gap;
            if (!b_q && c_mark && (pn_gap != '0)) begin
              gp_d = '0;
              if (gap_dist <= DW'(cfg_i.gap_frames)) begin
                p_d  = pn_gap;
                st_d = ST_FILL;
              end
            end
          end
          PH_COUNT, PH_EMIT: begin
            gp_d = pn_seg;
            if (b_q && (!c_mark || i_last) && (pn_seg != '0)) begin
              gp_d = '0;
              if (ph_q == PH_COUNT) begin
                if (seg_cnt_q < SW'(MAX_SEGMENTS)) begin
                  seg_cnt_d = seg_cnt_q + SW'(1);
                end else begin
                  segovf_d = 1'b1;
                end
              end else if (emit_cnt_q < seg_cnt_q) begin
                p_d  = pn_seg;
                st_d = ST_MUL;
              end
            end
          end
          default: st_d = ST_NEXT;
        endcase
      end
      ST_WRD: begin
        if (walk_range) begin
          st_d = ST_WCK;
        end else if (!dir_q && up_q) begin
          p_d   = i_q;
          dir_d = 1'b1;
          up_d  = 1'b0;
          st_d  = ST_WRD;
        end else begin
          st_d = ST_NEXT;
        end
      end
      ST_WCK: begin
        if (f_walk) begin
          p_d  = dir_q ? p_q + IW'(1) : p_m1;
          st_d = ST_WRD;
        end else if (!dir_q && up_q) begin
          p_d   = i_q;
          dir_d = 1'b1;
          up_d  = 1'b0;
          st_d  = ST_WRD;
        end else begin
          st_d = ST_NEXT;
        end
      end
      ST_FILL: begin
        if (p_q == i_q) begin
          st_d = ST_NEXT;
        end else begin
          p_d = p_q + IW'(1);
        end
      end
      ST_MUL: begin
        start_d = start_prod[31:0];
        end_d   = i_last ? cfg_i.total_samples : end_prod[31:0];
        st_d    = ST_EMIT;
      end
      ST_EMIT: begin
        if (seg_taken_i) begin
          emit_cnt_d = emit_cnt_q + SW'(1);
          st_d       = ST_NEXT;
        end
      end
      ST_EMPTY: begin
        if (seg_taken_i) begin
          st_d = ST_FIN;
        end
      end
      ST_NEXT: begin
        if ((i_q + IW'(2)) <= n_q) begin
          i_d  = i_q + IW'(1);
          st_d = ST_RD0;
        end else begin
          st_d = ST_PEND;
        end
      end
      ST_PEND: begin
        st_d = ST_START;
        unique case (ph_q)
          PH_GROW: begin
            if (pass_q == 2'd3) begin
              ph_d = PH_GAP;
            end else begin
              pass_d = pass_q + 2'd1;
            end
          end
          PH_GAP: ph_d = PH_COUNT;
          PH_COUNT: begin
            if (seg_cnt_q == '0) begin
              st_d = ST_EMPTY;
            end else begin
              ph_d = PH_EMIT;
            end
          end
          PH_EMIT: st_d = ST_FIN;
          default: st_d = ST_FIN;
        endcase
      end
      ST_FIN: begin
        cnt_d      = '0;
        drop_d     = 1'b0;
        segovf_d   = 1'b0;
        seg_cnt_d  = '0;
        emit_cnt_d = '0;
        ph_d       = PH_GROW;
        pass_d     = 2'd0;
        st_d       = ST_LOAD;
      end
      default: st_d = ST_LOAD;
    endcase
  end

  // memory controls and outputs
  always_comb begin
    mark_we    = 1'b0;
    flag_we    = 1'b0;
    mem_re     = 1'b0;
    waddr      = '0;
    raddr      = '0;
    mark_wdata = 1'b1;
    flag_wdata = {in_data_i.frame_energy > cfg_i.energy_low,
                  in_data_i.frame_zcr > cfg_i.zcr_threshold};
    in_ready_o = 1'b0;
    seg_req_o  = '0;
    unique case (st_q)
      ST_LOAD: begin
        in_ready_o = 1'b1;
        waddr      = cnt_q[AW-1:0];
        mark_wdata = in_data_i.frame_energy > cfg_i.energy_high;
        if (in_acc && room) begin
          mark_we = 1'b1;
          flag_we = 1'b1;
        end
      end
      ST_RD0: begin
        mem_re = 1'b1;
        raddr  = i_m2[AW-1:0];
      end
      ST_RD1: begin
        mem_re = 1'b1;
        raddr  = i_m1[AW-1:0];
      end
      ST_RD2: begin
        mem_re = 1'b1;
        raddr  = i_m1[AW-1:0] + AW'(1);
      end
      ST_WRD: begin
        mem_re = walk_range;
        raddr  = p_m1[AW-1:0];
      end
      ST_WCK: begin
        mark_we = f_walk;
        waddr   = p_m1[AW-1:0];
      end
      ST_FILL: begin
        mark_we = 1'b1;
        waddr   = p_m1[AW-1:0];
      end
      ST_EMIT: begin
        seg_req_o.valid           = 1'b1;
        seg_req_o.seg.seg_start   = start_q + 32'd1;
        seg_req_o.seg.seg_end     = end_q;
        seg_req_o.seg.seg_valid   = 1'b1;
        seg_req_o.seg.last_result = (emit_cnt_q + SW'(1)) == seg_cnt_q;
        seg_req_o.seg.overflow    = drop_q || segovf_q;
      end
      ST_EMPTY: begin
        seg_req_o.valid           = 1'b1;
        seg_req_o.seg.last_result = 1'b1;
        seg_req_o.seg.overflow    = drop_q || segovf_q;
      end
      default: begin
        mem_re = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q       <= ST_LOAD;
      ph_q       <= PH_GROW;
      pass_q     <= 2'd0;
      cnt_q      <= '0;
      drop_q     <= 1'b0;
      segovf_q   <= 1'b0;
      seg_cnt_q  <= '0;
      emit_cnt_q <= '0;
      dir_q      <= 1'b0;
      up_q       <= 1'b0;
    end else begin
      st_q       <= st_d;
      ph_q       <= ph_d;
      pass_q     <= pass_d;
      cnt_q      <= cnt_d;
      drop_q     <= drop_d;
      segovf_q   <= segovf_d;
      seg_cnt_q  <= seg_cnt_d;
      emit_cnt_q <= emit_cnt_d;
      dir_q      <= dir_d;
      up_q       <= up_d;
    end
  end

  always_ff @(posedge clk_i) begin
    n_q     <= n_d;
    i_q     <= i_d;
    p_q     <= p_d;
    gp_q    <= gp_d;
    a_q     <= a_d;
    b_q     <= b_d;
    bf_q    <= bf_d;
    start_q <= start_d;
    end_q   <= end_d;
  end

  `DTVAD_ASSERT(a_emit_le_cnt, clk_i, rst_ni, emit_cnt_q <= seg_cnt_q)
  `DTVAD_ASSERT(a_cnt_cap, clk_i, rst_ni, cnt_q <= IW'(MAX_FRAMES))
  `DTVAD_ASSERT(a_last_starts, clk_i, rst_ni,
    (in_acc && in_data_i.last_frame) |=> (st_q == ST_START))

endmodule

// ===== sv/dual_threshold_vad_segmenter_core.sv =====
// Dual-threshold VAD segmenter top level: config registers, output register.
// Depends on dtvad_pkg and dtvad_seq.
//
// Use: write registers on the cfg channel (index 0..5) while idle, then send
// one request per frame on the in channel (energy, crossing rate, last flag).
// Frames load at one per cycle; each stores three flags in on-chip memories.
// The request carrying last_frame starts the decision; no frame is taken
// until the final result of the run has entered the output register.
// Decision: four grow passes, a gap pass and two segment passes over
// frames 2..n-1; each step reads its frame and its two neighbours in turn
// through the single read port of the mark and flag memories, walks and
// fills go frame by frame, and each segment is emitted in turn.
// Results leave through a registered out channel: one request per segment,
// or a single request with seg_valid low when no speech was found;
// last_result marks the final one. A stalled receiver holds the register
// and the sequencer waits. Reset restores register defaults and clears
// the frame count; no memory clearing pass is needed.
`timescale 1ns / 1ps
module dual_threshold_vad_segmenter_core #(
  parameter int unsigned MAX_FRAMES   = dtvad_pkg::MaxFramesDef,
  parameter int unsigned MAX_SEGMENTS = dtvad_pkg::MaxSegmentsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [dtvad_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  logic [31:0]                       cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  dtvad_pkg::frame_t                 in_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output dtvad_pkg::seg_t                   out_data_o
);
  import dtvad_pkg::*;

  cfg_t     cfg_q, cfg_d;
  seg_req_t seg_req;
  logic     seg_taken;
  logic     out_valid_q, out_valid_d;
  seg_t     out_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_ENERGY_HIGH:   cfg_d.energy_high   = cfg_data_i;
        REG_ENERGY_LOW:    cfg_d.energy_low    = cfg_data_i;
        REG_ZCR_THRESHOLD: cfg_d.zcr_threshold = cfg_data_i[15:0];
        REG_GAP_FRAMES:    cfg_d.gap_frames    = cfg_data_i[11:0];
        REG_FRAME_SHIFT:   cfg_d.frame_shift   = cfg_data_i[15:0];
        REG_TOTAL_SAMPLES: cfg_d.total_samples = cfg_data_i;
        default:           cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.energy_high   <= 32'd10000;
      cfg_q.energy_low    <= 32'd2000;
      cfg_q.zcr_threshold <= 16'd29491;
      cfg_q.gap_frames    <= 12'd50;
      cfg_q.frame_shift   <= 16'd160;
      cfg_q.total_samples <= 32'd0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  dtvad_seq #(
    .MAX_FRAMES  (MAX_FRAMES),
    .MAX_SEGMENTS(MAX_SEGMENTS)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .seg_req_o  (seg_req),
    .seg_taken_i(seg_taken)
  );

  assign seg_taken = seg_req.valid && (!out_valid_q || out_ready_i);

  always_comb begin
    out_valid_d = out_valid_q;
    if (seg_taken) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seg_taken) begin
      out_q <= seg_req.seg;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
